// ===== rtl/core/grle_pkg.sv =====
// Shared types, sizes, opcode codes and opcode decode for the grid raster line engine.
// No dependencies; imported by the top level, the controller, the datapath and the testbench.
package grle_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int EW         = $clog2(MAX_WIDTH + 1);
  localparam int EH         = $clog2(MAX_HEIGHT + 1);
  localparam int PW         = YW + EW;

  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

  localparam int COORD_W = 18;
  localparam int DIST_W  = 17;
  localparam int CNT_W   = 18;
  localparam int ERR_W   = 20;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [DIST_W-1:0]         dist_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic signed [ERR_W-1:0]   err_t;

  localparam logic [3:0] OP_READ       = 4'd0;
  localparam logic [3:0] OP_CELL_SET   = 4'd1;
  localparam logic [3:0] OP_CELL_ADD   = 4'd2;
  localparam logic [3:0] OP_CELL_SUB   = 4'd3;
  localparam logic [3:0] OP_LINE8_SET  = 4'd4;
  localparam logic [3:0] OP_LINE8_ADD  = 4'd5;
  localparam logic [3:0] OP_LINE8_SUB  = 4'd6;
  localparam logic [3:0] OP_LINE4_SET  = 4'd7;
  localparam logic [3:0] OP_LINE4_ADD  = 4'd8;
  localparam logic [3:0] OP_LINE4_SUB  = 4'd9;
  localparam logic [3:0] OP_LINE8_TEST = 4'd10;
  localparam logic [3:0] OP_LINE4_TEST = 4'd11;
  localparam logic [3:0] OP_RECT_SET   = 4'd12;
  localparam logic [3:0] OP_RECT_ADD   = 4'd13;
  localparam logic [3:0] OP_RECT_SUB   = 4'd14;
  localparam logic [3:0] OP_SQR_TEST   = 4'd15;

  localparam logic [2:0] KIND_CELL   = 3'd0;
  localparam logic [2:0] KIND_LINE8  = 3'd1;
  localparam logic [2:0] KIND_LINE4  = 3'd2;
  localparam logic [2:0] KIND_RECT   = 3'd3;
  localparam logic [2:0] KIND_SQUARE = 3'd4;

  localparam logic [1:0] MODE_SET = 2'd0;
  localparam logic [1:0] MODE_ADD = 2'd1;
  localparam logic [1:0] MODE_SUB = 2'd2;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] mode;
    logic       is_test;
    logic       is_read;
  } op_info_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic setup1;
    logic setup2;
    logic walk;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic walk_last;
  } dp_stat_t;

  function automatic op_info_t decode_op(input logic [3:0] op);
    op_info_t info;
    info = '{kind: KIND_CELL, mode: MODE_SET, is_test: 1'b0, is_read: 1'b0};
    case (op) inside
      OP_READ:                                   info.is_read = 1'b1;
      OP_CELL_SET, OP_CELL_ADD, OP_CELL_SUB:     info.kind = KIND_CELL;
      OP_LINE8_SET, OP_LINE8_ADD, OP_LINE8_SUB,
      OP_LINE8_TEST:                             info.kind = KIND_LINE8;
      OP_LINE4_SET, OP_LINE4_ADD, OP_LINE4_SUB,
      OP_LINE4_TEST:                             info.kind = KIND_LINE4;
      OP_RECT_SET, OP_RECT_ADD, OP_RECT_SUB:     info.kind = KIND_RECT;
      default:                                   info.kind = KIND_SQUARE;
    endcase
    case (op) inside
      OP_CELL_ADD, OP_LINE8_ADD, OP_LINE4_ADD, OP_RECT_ADD: info.mode = MODE_ADD;
      OP_CELL_SUB, OP_LINE8_SUB, OP_LINE4_SUB, OP_RECT_SUB: info.mode = MODE_SUB;
      default:                                              info.mode = MODE_SET;
    endcase
    case (op) inside
      OP_LINE8_TEST, OP_LINE4_TEST, OP_SQR_TEST: info.is_test = 1'b1;
      default:                                   info.is_test = 1'b0;
    endcase
    return info;
  endfunction

endpackage

// ===== rtl/core/grid_raster_line_engine_unit.sv =====
// An accepted item passes SETUP1, SETUP2, WALK, DRAIN and DONE; the result is strobed
// in DONE and busy falls on the return to IDLE. WALK takes N steps: 1 for read and cell
// ops, max(|dx|,|dy|)+1 for line8, |dx|+|dy|+1 for line4, the clipped area (or 1 when
// empty) for rectangles and (2r+1)^2 for the square test; the memory pipeline visits one
// cell per cycle. After reset a clearing pass zeroes the grid with busy high; config
// writes are taken throughout. The receiver cannot stall the result.
module grid_raster_line_engine_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [3:0]                     in_opcode,
  input  logic signed [15:0]             in_start_x,
  input  logic signed [15:0]             in_start_y,
  input  logic signed [15:0]             in_end_x,
  input  logic signed [15:0]             in_end_y,
  input  logic [7:0]                     in_operand_value,
  input  logic [6:0]                     in_radius,
  output logic                           out_valid,
  output logic [7:0]                     out_read_value,
  output logic                           out_blocked,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [grle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [grle_pkg::CFG_W-1:0]     cfg_data
);
  import grle_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  grle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  grle_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_opcode        (in_opcode),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .in_operand_value (in_operand_value),
    .in_radius        (in_radius),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .read_value       (out_read_value),
    .blocked          (out_blocked)
  );

endmodule

// ===== rtl/core/grle_ctrl.sv =====
// Controller state machine: clearing pass, item setup, cell walk, pipeline drain, result.
// Depends on grle_pkg for the command and status structs.
module grle_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_valid,
  output grle_pkg::ctrl_cmd_t cmd,
  input  grle_pkg::dp_stat_t  stat
);
  import grle_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SETUP1 = 3'd2;
  localparam logic [2:0] ST_SETUP2 = 3'd3;
  localparam logic [2:0] ST_WALK   = 3'd4;
  localparam logic [2:0] ST_DRAIN  = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       drain_r, drain_nxt;

  always_comb begin
    state_nxt = state_r;
    drain_nxt = drain_r;
    cmd       = '0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP1;
        end
      end
      ST_SETUP1: begin
        cmd.setup1 = 1'b1;
        state_nxt  = ST_SETUP2;
      end
      ST_SETUP2: begin
        cmd.setup2 = 1'b1;
        state_nxt  = ST_WALK;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_last) begin
          drain_nxt = 1'b0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      drain_r <= drain_nxt;
    end
  end

endmodule

// ===== rtl/core/grle_dp.sv =====
// Datapath: config registers, shape walker, address stage, grid memory and cell update.
// Depends on grle_pkg; driven by grle_ctrl through the command struct.
module grle_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  grle_pkg::ctrl_cmd_t          cmd,
  output grle_pkg::dp_stat_t           stat,
  input  logic [3:0]                   in_opcode,
  input  logic signed [15:0]           in_start_x,
  input  logic signed [15:0]           in_start_y,
  input  logic signed [15:0]           in_end_x,
  input  logic signed [15:0]           in_end_y,
  input  logic [7:0]                   in_operand_value,
  input  logic [6:0]                   in_radius,
  input  logic                         cfg_we,
  input  logic [grle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [grle_pkg::CFG_W-1:0]   cfg_data,
  output logic [7:0]                   read_value,
  output logic                         blocked
);
  import grle_pkg::*;

  logic [CFG_W-1:0] gw_r, gh_r;
  logic [EW-1:0]    eff_w;
  logic [EH-1:0]    eff_h;
  coord_t           eff_wc, eff_hc;

  logic [ADDR_W-1:0] clr_cnt_r;
  logic [7:0]        mem [DEPTH];

  op_info_t           info_r;
  logic signed [15:0] x1_r, y1_r, x2_r, y2_r;
  logic [7:0]         v_r;
  logic [6:0]         r_r;

  dist_t  dx_r, dy_r;
  logic   sxn_r, syn_r, steep_r, empty_r;
  coord_t xlo_r, xhi_r, ylo_r, yhi_r;
  coord_t cx_r, cy_r, cx_nxt, cy_nxt;
  err_t   d_r, d_nxt, inc_a_r, inc_b_r;
  cnt_t   cnt_r;
  logic   last_now, is_region;

  coord_t dfx, dfy;
  coord_t rxlo, rxhi, rylo, ryhi;

  logic              s1_valid_r, s1_inside_r, s2_valid_r, s2_inside_r;
  logic [ADDR_W-1:0] s1_addr_r, s2_addr_r;
  logic [7:0]        rdata_r, cell_val, new_val;
  logic [8:0]        sum9;
  logic              cell_ok;
  logic [PW-1:0]     prod;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [7:0]        wd;
  logic [7:0]        rd_r;
  logic              hit_r;

  assign eff_w  = (32'(gw_r) > MAX_WIDTH)  ? EW'(MAX_WIDTH)  : EW'(gw_r);
  assign eff_h  = (32'(gh_r) > MAX_HEIGHT) ? EH'(MAX_HEIGHT) : EH'(gh_r);
  assign eff_wc = coord_t'(eff_w);
  assign eff_hc = coord_t'(eff_h);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= CFG_W'(256);
      gh_r <= CFG_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  gw_r <= cfg_data;
        CFG_GRID_HEIGHT: gh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clear) clr_cnt_r <= clr_cnt_r + 1'b1;
  end

  assign dfx   = coord_t'(x2_r) - coord_t'(x1_r);
  assign dfy   = coord_t'(y2_r) - coord_t'(y1_r);
  assign rxlo  = xlo_r[COORD_W-1] ? '0 : xlo_r;
  assign rylo  = ylo_r[COORD_W-1] ? '0 : ylo_r;
  assign rxhi  = (xhi_r > eff_wc - coord_t'(1)) ? eff_wc - coord_t'(1) : xhi_r;
  assign ryhi  = (yhi_r > eff_hc - coord_t'(1)) ? eff_hc - coord_t'(1) : yhi_r;

  assign is_region = (info_r.kind == KIND_RECT) || (info_r.kind == KIND_SQUARE);
  assign last_now  = is_region ? ((cx_r == xhi_r) && (cy_r == yhi_r)) : (cnt_r == '0);
  assign stat.walk_last  = empty_r || last_now;
  assign stat.clear_done = (clr_cnt_r == ADDR_W'(DEPTH - 1));

  always_comb begin
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    d_nxt  = d_r;
    case (info_r.kind)
      KIND_LINE8: begin
        if (steep_r) cy_nxt = syn_r ? cy_r - coord_t'(1) : cy_r + coord_t'(1);
        else         cx_nxt = sxn_r ? cx_r - coord_t'(1) : cx_r + coord_t'(1);
        if (d_r > 0) begin
          d_nxt = d_r + inc_a_r;
          if (steep_r) cx_nxt = sxn_r ? cx_r - coord_t'(1) : cx_r + coord_t'(1);
          else         cy_nxt = syn_r ? cy_r - coord_t'(1) : cy_r + coord_t'(1);
        end else begin
          d_nxt = d_r + inc_b_r;
        end
      end
      KIND_LINE4: begin
        if (d_r >= 0) begin
          cy_nxt = syn_r ? cy_r - coord_t'(1) : cy_r + coord_t'(1);
          d_nxt  = d_r + inc_a_r;
        end else begin
          cx_nxt = sxn_r ? cx_r - coord_t'(1) : cx_r + coord_t'(1);
          d_nxt  = d_r + inc_b_r;
        end
      end
      KIND_RECT, KIND_SQUARE: begin
        if (cx_r == xhi_r) begin
          cx_nxt = xlo_r;
          cy_nxt = cy_r + coord_t'(1);
        end else begin
          cx_nxt = cx_r + coord_t'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      info_r <= decode_op(in_opcode);
      x1_r   <= in_start_x;
      y1_r   <= in_start_y;
      x2_r   <= in_end_x;
      y2_r   <= in_end_y;
      v_r    <= in_operand_value;
      r_r    <= in_radius;
    end
    if (cmd.setup1) begin
      sxn_r <= dfx[COORD_W-1];
      syn_r <= dfy[COORD_W-1];
      dx_r  <= dfx[COORD_W-1] ? DIST_W'(-dfx) : DIST_W'(dfx);
      dy_r  <= dfy[COORD_W-1] ? DIST_W'(-dfy) : DIST_W'(dfy);
      if (info_r.kind == KIND_SQUARE) begin
        xlo_r <= coord_t'(x1_r) - coord_t'(r_r);
        xhi_r <= coord_t'(x1_r) + coord_t'(r_r);
        ylo_r <= coord_t'(y1_r) - coord_t'(r_r);
        yhi_r <= coord_t'(y1_r) + coord_t'(r_r);
      end else begin
        xlo_r <= (x1_r < x2_r) ? coord_t'(x1_r) : coord_t'(x2_r);
        xhi_r <= (x1_r < x2_r) ? coord_t'(x2_r) : coord_t'(x1_r);
        ylo_r <= (y1_r < y2_r) ? coord_t'(y1_r) : coord_t'(y2_r);
        yhi_r <= (y1_r < y2_r) ? coord_t'(y2_r) : coord_t'(y1_r);
      end
    end
    if (cmd.setup2) begin
      steep_r <= dy_r > dx_r;
      case (info_r.kind)
        KIND_LINE8: begin
          empty_r <= 1'b0;
          cx_r    <= coord_t'(x1_r);
          cy_r    <= coord_t'(y1_r);
          cnt_r   <= CNT_W'((dy_r > dx_r) ? dy_r : dx_r);
          d_r     <= (dy_r > dx_r) ? err_t'({dx_r, 1'b0}) - err_t'(dy_r)
                                   : err_t'({dy_r, 1'b0}) - err_t'(dx_r);
          inc_a_r <= (dy_r > dx_r) ? err_t'({dx_r, 1'b0}) - err_t'({dy_r, 1'b0})
                                   : err_t'({dy_r, 1'b0}) - err_t'({dx_r, 1'b0});
          inc_b_r <= (dy_r > dx_r) ? err_t'({dx_r, 1'b0}) : err_t'({dy_r, 1'b0});
        end
        KIND_LINE4: begin
          empty_r <= 1'b0;
          cx_r    <= coord_t'(x1_r);
          cy_r    <= coord_t'(y1_r);
          cnt_r   <= CNT_W'(dx_r) + CNT_W'(dy_r);
          d_r     <= err_t'(dy_r) - err_t'(dx_r);
          inc_a_r <= -err_t'({dx_r, 1'b0});
          inc_b_r <= err_t'({dy_r, 1'b0});
        end
        KIND_RECT: begin
          cnt_r   <= '0;
          cx_r    <= rxlo;
          cy_r    <= rylo;
          xlo_r   <= rxlo;
          xhi_r   <= rxhi;
          ylo_r   <= rylo;
          yhi_r   <= ryhi;
          empty_r <= (rxlo > rxhi) || (rylo > ryhi);
        end
        KIND_SQUARE: begin
          empty_r <= 1'b0;
          cnt_r   <= '0;
          cx_r    <= xlo_r;
          cy_r    <= ylo_r;
        end
        default: begin
          empty_r <= 1'b0;
          cnt_r   <= '0;
          cx_r    <= coord_t'(x1_r);
          cy_r    <= coord_t'(y1_r);
        end
      endcase
    end
    if (cmd.walk && !stat.walk_last) begin
      cx_r  <= cx_nxt;
      cy_r  <= cy_nxt;
      d_r   <= d_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // address stage
  assign cell_ok = !cx_r[COORD_W-1] && !cy_r[COORD_W-1] && (cx_r < eff_wc) && (cy_r < eff_hc);
  assign prod    = PW'(cy_r[YW-1:0]) * PW'(eff_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd.walk && !empty_r;
      s2_valid_r <= s1_valid_r;
    end
    s1_inside_r <= cell_ok;
    s1_addr_r   <= ADDR_W'(prod + PW'(cx_r[XW-1:0]));
    s2_inside_r <= s1_inside_r;
    s2_addr_r   <= s1_addr_r;
    rdata_r     <= mem[s1_addr_r];
  end

  // update stage
  assign cell_val = s2_inside_r ? rdata_r : 8'hFF;
  assign sum9     = {1'b0, rdata_r} + {1'b0, v_r};

  always_comb begin
    case (info_r.mode)
      MODE_ADD: new_val = sum9[8] ? 8'hFF : sum9[7:0];
      MODE_SUB: new_val = (rdata_r < v_r) ? 8'h00 : rdata_r - v_r;
      default:  new_val = v_r;
    endcase
  end

  assign we = cmd.clear ||
              (s2_valid_r && s2_inside_r && !info_r.is_test && !info_r.is_read);
  assign wa = cmd.clear ? clr_cnt_r : s2_addr_r;
  assign wd = cmd.clear ? 8'h00 : new_val;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_r  <= 8'h00;
      hit_r <= 1'b0;
    end else if (s2_valid_r) begin
      if (info_r.is_read) rd_r <= cell_val;
      if (info_r.is_test && (cell_val > v_r)) hit_r <= 1'b1;
    end
  end

  assign read_value = rd_r;
  assign blocked    = hit_r;

endmodule

// ===== rtl/core/grle_checker.sv =====
// Port-level checks for the grid raster line engine, bound to the top level.
// Depends only on the top level's ports.
module grle_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [7:0] out_read_value,
  input logic       out_blocked
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after item accepted");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_blocked && (out_read_value != 8'h00)))
    else $error("read value and blocked both set");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && busy))
    else $error("result or idle right after reset");

endmodule

bind grid_raster_line_engine_unit grle_checker u_grle_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_read_value (out_read_value),
  .out_blocked    (out_blocked)
);

// ===== bench/testbench.sv =====
// Self-checking bench for grid_raster_line_engine_unit: cell, line, rectangle and test
// commands are predicted on a shadow grid and every result is compared in order.
// Depends on grle_pkg and the engine RTL only.
`timescale 1ns / 1ps

module testbench;
  import grle_pkg::*;

  localparam int STALL_LIMIT = 400000;

  typedef struct {
    logic [3:0]         op;
    logic signed [15:0] x1, y1, x2, y2;
    logic [7:0]         val;
    logic [6:0]         rad;
  } cmd_t;

  typedef struct {
    logic [7:0] rd;
    logic       blk;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [3:0] in_opcode = '0;
  logic signed [15:0] in_start_x = '0, in_start_y = '0, in_end_x = '0, in_end_y = '0;
  logic [7:0] in_operand_value = '0;
  logic [6:0] in_radius = '0;
  logic out_valid;
  logic [7:0] out_read_value;
  logic out_blocked;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  byte unsigned shadow_grid [DEPTH];
  int shadow_w = MAX_WIDTH;
  int shadow_h = MAX_HEIGHT;
  bit probe_hit;
  answer_t pending_answers [$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;

  grid_raster_line_engine_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit on_grid(int x, int y);
    return x >= 0 && y >= 0 && x < shadow_w && y < shadow_h;
  endfunction

  function automatic byte unsigned cell_value(int x, int y);
    if (!on_grid(x, y)) return 8'hFF;
    return shadow_grid[y * shadow_w + x];
  endfunction

  function automatic void cell_write(int x, int y, logic [1:0] mode, int v);
    int a;
    int c;
    if (!on_grid(x, y)) return;
    a = y * shadow_w + x;
    c = shadow_grid[a];
    if (mode == MODE_SET) c = v;
    else if (mode == MODE_ADD) c = (c + v > 255) ? 255 : c + v;
    else c = (c < v) ? 0 : c - v;
    shadow_grid[a] = 8'(c);
  endfunction

  function automatic void touch(int x, int y, bit probe, logic [1:0] mode, int v);
    if (probe) begin
      if (cell_value(x, y) > v) probe_hit = 1'b1;
    end else begin
      cell_write(x, y, mode, v);
    end
  endfunction

  function automatic void walk_line8(int x1, int y1, int x2, int y2, bit probe,
                                     logic [1:0] mode, int v);
    int dx, dy, sx, sy, cx, cy, major, minor, d;
    bit steep;
    dx = (x2 >= x1) ? x2 - x1 : x1 - x2;
    dy = (y2 >= y1) ? y2 - y1 : y1 - y2;
    sx = (x2 >= x1) ? 1 : -1;
    sy = (y2 >= y1) ? 1 : -1;
    cx = x1;
    cy = y1;
    steep = dy > dx;
    major = steep ? dy : dx;
    minor = steep ? dx : dy;
    d = 2 * minor - major;
    touch(cx, cy, probe, mode, v);
    for (int k = 0; k < major; k++) begin
      if (steep) cy += sy;
      else cx += sx;
      if (d <= 0) begin
        d += 2 * minor;
      end else begin
        d += 2 * (minor - major);
        if (steep) cx += sx;
        else cy += sy;
      end
      touch(cx, cy, probe, mode, v);
    end
  endfunction

  function automatic void walk_line4(int x1, int y1, int x2, int y2, bit probe,
                                     logic [1:0] mode, int v);
    longint dx, dy, n, ax, ay, tx, ty;
    int sx, sy, cx, cy;
    dx = (x2 >= x1) ? x2 - x1 : x1 - x2;
    dy = (y2 >= y1) ? y2 - y1 : y1 - y2;
    n = dx + dy;
    sx = (x2 >= x1) ? 1 : -1;
    sy = (y2 >= y1) ? 1 : -1;
    cx = x1;
    cy = y1;
    ax = 0;
    ay = 0;
    tx = dx;
    ty = dy;
    touch(cx, cy, probe, mode, v);
    for (longint i = 1; i <= n; i++) begin
      if (ax - tx >= ay - ty) begin
        ay += n;
        cy += sy;
      end else begin
        ax += n;
        cx += sx;
      end
      touch(cx, cy, probe, mode, v);
      tx += dx;
      ty += dy;
    end
  endfunction

  function automatic answer_t apply_command(cmd_t c);
    answer_t r;
    op_info_t info;
    int x1, y1, x2, y2, v, xa, xb, ya, yb;
    info = decode_op(c.op);
    x1 = c.x1;
    y1 = c.y1;
    x2 = c.x2;
    y2 = c.y2;
    v = c.val;
    r.rd = '0;
    probe_hit = 1'b0;
    case (info.kind)
      KIND_CELL: begin
        if (info.is_read) r.rd = cell_value(x1, y1);
        else cell_write(x1, y1, info.mode, v);
      end
      KIND_LINE8: walk_line8(x1, y1, x2, y2, info.is_test, info.mode, v);
      KIND_LINE4: walk_line4(x1, y1, x2, y2, info.is_test, info.mode, v);
      KIND_RECT: begin
        xa = (x1 < x2) ? x1 : x2;
        xb = (x1 < x2) ? x2 : x1;
        ya = (y1 < y2) ? y1 : y2;
        yb = (y1 < y2) ? y2 : y1;
        if (xa < 0) xa = 0;
        if (ya < 0) ya = 0;
        if (xb > shadow_w - 1) xb = shadow_w - 1;
        if (yb > shadow_h - 1) yb = shadow_h - 1;
        for (int y = ya; y <= yb; y++)
          for (int x = xa; x <= xb; x++)
            cell_write(x, y, info.mode, v);
      end
      default: begin
        for (int ox = -int'(c.rad); ox <= int'(c.rad); ox++)
          for (int oy = -int'(c.rad); oy <= int'(c.rad); oy++)
            if (cell_value(x1 + ox, y1 + oy) > v) probe_hit = 1'b1;
      end
    endcase
    r.blk = probe_hit;
    return r;
  endfunction

  task automatic send_command(cmd_t c);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_opcode <= c.op;
    in_start_x <= c.x1;
    in_start_y <= c.y1;
    in_end_x <= c.x2;
    in_end_y <= c.y2;
    in_operand_value <= c.val;
    in_radius <= c.rad;
    do @(posedge clk); while (busy);
    pending_answers.push_back(apply_command(c));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_GRID_WIDTH) shadow_w = (value > MAX_WIDTH) ? MAX_WIDTH : value;
    else shadow_h = (value > MAX_HEIGHT) ? MAX_HEIGHT : value;
  endtask

  task automatic set_grid(int w, int h);
    drain_results();
    write_register(CFG_GRID_WIDTH, w);
    write_register(CFG_GRID_HEIGHT, h);
  endtask

  function automatic cmd_t make_cmd(logic [3:0] op, int x1, int y1, int x2, int y2,
                                    int v, int r);
    cmd_t c;
    c.op = op;
    c.x1 = 16'(x1);
    c.y1 = 16'(y1);
    c.x2 = 16'(x2);
    c.y2 = 16'(y2);
    c.val = 8'(v);
    c.rad = 7'(r);
    return c;
  endfunction

  function automatic int pick_coord(int span);
    if ($urandom_range(0, 9) == 0) return $signed(16'($urandom()));
    return $urandom_range(0, span + 8) - 4;
  endfunction

  function automatic int nudge(int p);
    int q;
    q = p + $urandom_range(0, 24) - 12;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  task automatic test_cells();
    send_command(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(OP_CELL_SET, 0, 0, 0, 0, 255, 0));
    send_command(make_cmd(OP_CELL_ADD, 0, 0, 0, 0, 10, 0));
    send_command(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(OP_CELL_SUB, 0, 0, 0, 0, 255, 0));
    send_command(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(OP_CELL_SET, -1, 5, 0, 0, 9, 0));
    send_command(make_cmd(OP_READ, -32768, 32767, 0, 0, 0, 0));
    send_command(make_cmd(OP_READ, 32767, -32768, 0, 0, 0, 0));
    send_command(make_cmd(OP_CELL_SET, 255, 255, 0, 0, 128, 0));
    send_command(make_cmd(OP_READ, 255, 255, 0, 0, 0, 0));
  endtask

  task automatic test_lines();
    send_command(make_cmd(OP_LINE8_SET, 2, 3, 9, 5, 40, 0));
    send_command(make_cmd(OP_LINE8_ADD, 4, 4, 4, 4, 250, 0));
    send_command(make_cmd(OP_LINE4_ADD, 9, 5, 2, 10, 30, 0));
    send_command(make_cmd(OP_LINE8_TEST, 0, 8, 12, 0, 0, 0));
    send_command(make_cmd(OP_LINE4_TEST, -5, -5, 300, 3, 255, 0));
    send_command(make_cmd(OP_LINE8_SUB, 9, 5, 2, 3, 35, 0));
    send_command(make_cmd(OP_LINE4_SET, 1, 20, 1, 12, 7, 0));
    send_command(make_cmd(OP_LINE4_SUB, 3, 10, 9, 5, 255, 0));
    send_command(make_cmd(OP_LINE8_TEST, -32768, -32768, 32767, 32767, 254, 0));
  endtask

  task automatic test_rects_and_squares();
    send_command(make_cmd(OP_RECT_SET, 10, 10, 5, 7, 7, 0));
    send_command(make_cmd(OP_RECT_ADD, 6, 8, 12, 14, 200, 0));
    send_command(make_cmd(OP_RECT_SUB, -3, 300, 7, 9, 100, 0));
    send_command(make_cmd(OP_SQR_TEST, 5, 7, 0, 0, 6, 0));
    send_command(make_cmd(OP_SQR_TEST, 0, 0, 0, 0, 255, 127));
    send_command(make_cmd(OP_SQR_TEST, 128, 128, 0, 0, 0, 85));
  endtask

  task automatic test_random_phase(int count);
    cmd_t c;
    int span;
    span = (shadow_w > shadow_h) ? shadow_w : shadow_h;
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) begin
      c.op = 4'($urandom_range(0, 15));
      c.x1 = 16'(pick_coord(span));
      c.y1 = 16'(pick_coord(span));
      if ($urandom_range(0, 4) == 0 && c.x1 > -20 && c.x1 < 300) begin
        c.x2 = 16'(pick_coord(span) % 512);
        c.y2 = 16'(pick_coord(span) % 512);
      end else begin
        c.x2 = 16'(nudge(c.x1));
        c.y2 = 16'(nudge(c.y1));
      end
      c.val = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(250, 255))
                                          : 8'($urandom_range(0, 255));
      c.rad = ($urandom_range(0, 60) == 0) ? 7'($urandom_range(0, 127))
                                           : 7'($urandom_range(0, 4));
      if (c.op == OP_RECT_SET || c.op == OP_RECT_ADD || c.op == OP_RECT_SUB) begin
        c.x2 = 16'(nudge(c.x1));
        c.y2 = 16'(nudge(c.y1));
      end
      send_command(c);
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk) begin
    answer_t e;
    if (out_valid) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result rd=%0d blk=%0b",
                                       out_read_value, out_blocked);
      end else begin
        e = pending_answers.pop_front();
        if (out_read_value !== e.rd || out_blocked !== e.blk) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: read_value exp %0d got %0d, blocked exp %0b got %0b",
                     e.rd, out_read_value, e.blk, out_blocked);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    foreach (shadow_grid[i]) shadow_grid[i] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_cells();
    test_lines();
    test_rects_and_squares();
    test_random_phase(120);
    set_grid(16, 12);
    test_random_phase(110);
    set_grid(0, 40);
    test_random_phase(40);
    set_grid(511, 5);
    test_random_phase(90);
    set_grid(1, 511);
    test_random_phase(80);
    set_grid(300, 0);
    test_random_phase(30);
    set_grid(40, 30);
    send_command(make_cmd(OP_RECT_SET, -32768, -32768, 32767, 32767, 3, 0));
    test_random_phase(140);
    set_grid(256, 256);
    test_random_phase(120);
    drain_results();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== grid_raster_line_engine_unit.f =====
rtl/core/grle_pkg.sv
rtl/core/grle_ctrl.sv
rtl/core/grle_dp.sv
rtl/core/grid_raster_line_engine_unit.sv
rtl/core/grle_checker.sv
bench/testbench.sv
